// ----- rtl/grip_dwell_acquire_qualifier_top_assert.svh -----
// ----------------------------------------------------------------------------
// Grip dwell acquire qualifier assertion macros
// Clocked assertion wrappers; define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef GRIP_DWELL_ACQUIRE_QUALIFIER_TOP_ASSERT_SVH
`define GRIP_DWELL_ACQUIRE_QUALIFIER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Checked only while out of reset.
`define GDAQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Checked in every cycle, reset included.
`define GDAQ_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`else

`define GDAQ_ASSERT(label, prop, msg)
`define GDAQ_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

// ----- rtl/gdaq_pkg.sv -----
// ----------------------------------------------------------------------------
// Grip dwell acquire qualifier package
// Shared types, register indexes and stream layout constants.
// ----------------------------------------------------------------------------
`default_nettype none

package gdaq_pkg;

    // acquisition phase
    typedef enum logic [1:0] {
        PH_FREE      = 2'd0,
        PH_CANDIDATE = 2'd1,
        PH_SUPPORTED = 2'd2
    } phase_t;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACQUIRE_LIMIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TIME     = 1'd1;
    localparam int CFG_DATA_W = 32;

    // field widths
    localparam int ID_W   = 32;
    localparam int TIME_W = 32;
    localparam int DIST_W = 16;

    // stream widths (whole bytes)
    localparam int S_TDATA_W = 104;
    localparam int M_TDATA_W = 8;

endpackage

`default_nettype wire

// ----- rtl/grip_dwell_acquire_qualifier_top.sv -----
// ----------------------------------------------------------------------------
// Grip dwell acquire qualifier
// Three-state acquisition machine (free, candidate, supported) driven by
// one tracking sample per transaction.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake           Content
//  -------  ---  ------------------  ----------------------------------------
//  s_       in   s_tvalid/s_tready   one tracking sample per transaction
//  m_       out  m_tvalid/m_tready   state and acquired/released per sample
//  cfg_     in   cfg_we              acquire_limit, hold_time register writes
//
//  One transaction per cycle sustained while m_tready stays high; a result passes
//  through the input register, then the result register, before it is valid on m_.
//  aresetn is synchronous, active low; it puts the machine in free with no
//  binding and clears both configuration registers. No clearing pass.
//  When m_tready is low the result register holds, the input register still
//  fills once, and s_tready drops only when both are occupied.
//
`default_nettype none

`include "grip_dwell_acquire_qualifier_top_assert.svh"

module grip_dwell_acquire_qualifier_top (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,

    // tdata, lowest bit up: binding_id[31:0], sample_time[63:32],
    // support_distance[79:64], numbers_valid[80], session_focused[81],
    // grip_tracked[82], grip_held[83], pose_valid[84],
    // native_target_active[85], use_override[86], override_limit[102:87],
    // clear_request[103]
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [gdaq_pkg::S_TDATA_W-1:0]       s_tdata,

    // tdata, lowest bit up: support_state[1:0], acquired[2], released[3],
    // zero fill[7:4]
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    output logic [gdaq_pkg::M_TDATA_W-1:0]            m_tdata,

    input  wire logic                                 cfg_we,
    input  wire logic [gdaq_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [gdaq_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic                                   in_valid_reg, in_valid_next;
    logic [gdaq_pkg::S_TDATA_W-1:0]         in_data_reg,  in_data_next;
    logic                                   out_valid_reg, out_valid_next;
    logic [3:0]                             out_data_reg, out_data_next;

    gdaq_pkg::phase_t                       phase_reg, phase_next;
    logic [gdaq_pkg::ID_W-1:0]              bound_id_reg, bound_id_next;
    logic [gdaq_pkg::TIME_W-1:0]            cand_start_reg, cand_start_next;

    logic [gdaq_pkg::DIST_W-1:0]            acquire_limit_reg, acquire_limit_next;
    logic [gdaq_pkg::TIME_W-1:0]            hold_time_reg, hold_time_next;

    // ------------------------------------------------------------------
    // Handshake: result register frees up when empty or being taken
    // ------------------------------------------------------------------
    logic advance;
    logic fire;     // sample in the input register is processed this cycle

    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    // ------------------------------------------------------------------
    // Sample fields from the input register
    // ------------------------------------------------------------------
    logic [gdaq_pkg::ID_W-1:0]   bid;
    logic [gdaq_pkg::TIME_W-1:0] stime;
    logic [gdaq_pkg::DIST_W-1:0] sup_dist;
    logic                        nums_ok, focused, tracked, held, pose_ok, native;
    logic                        use_ovr, clear_req;
    logic [gdaq_pkg::DIST_W-1:0] ovr_limit;

    assign bid       = in_data_reg[31:0];
    assign stime     = in_data_reg[63:32];
    assign sup_dist  = in_data_reg[79:64];
    assign nums_ok   = in_data_reg[80];
    assign focused   = in_data_reg[81];
    assign tracked   = in_data_reg[82];
    assign held      = in_data_reg[83];
    assign pose_ok   = in_data_reg[84];
    assign native    = in_data_reg[85];
    assign use_ovr   = in_data_reg[86];
    assign ovr_limit = in_data_reg[102:87];
    assign clear_req = in_data_reg[103];

    // ------------------------------------------------------------------
    // Qualification and state step
    // ------------------------------------------------------------------
    logic [gdaq_pkg::DIST_W-1:0] limit;
    logic                        sample_ok;
    logic                        in_limit;
    logic                        bind_change;
    logic                        time_back;
    logic                        dwell_done;
    logic [gdaq_pkg::TIME_W-1:0] elapsed;
    gdaq_pkg::phase_t            base_phase;
    gdaq_pkg::phase_t            step_phase;
    logic [gdaq_pkg::ID_W-1:0]   step_bound;
    logic [gdaq_pkg::TIME_W-1:0] step_start;
    logic                        acquired, released;

    assign limit       = use_ovr ? ovr_limit : acquire_limit_reg;
    assign sample_ok   = (bid != '0) && nums_ok && focused && tracked && held
                         && pose_ok && !native;
    assign in_limit    = sup_dist <= limit;
    assign bind_change = bound_id_reg != bid;
    assign time_back   = stime < cand_start_reg;
    assign elapsed     = stime - cand_start_reg;
    assign dwell_done  = elapsed >= hold_time_reg;
    // a new binding restarts from free within the same sample
    assign base_phase  = bind_change ? gdaq_pkg::PH_FREE : phase_reg;

    always_comb begin
        step_phase = phase_reg;
        step_bound = bound_id_reg;
        step_start = cand_start_reg;
        if (clear_req || !sample_ok) begin
            step_phase = gdaq_pkg::PH_FREE;
            step_bound = '0;
            step_start = '0;
        end else begin
            step_bound = bid;
            step_phase = base_phase;
            if (bind_change) begin
                step_start = '0;
            end
            case (base_phase)
                gdaq_pkg::PH_CANDIDATE: begin
                    if (!in_limit) begin
                        step_phase = gdaq_pkg::PH_FREE;
                        step_start = '0;
                    end else if (time_back) begin
                        step_start = stime;
                    end else if (dwell_done) begin
                        step_phase = gdaq_pkg::PH_SUPPORTED;
                    end
                end
                gdaq_pkg::PH_SUPPORTED: begin
                    step_phase = gdaq_pkg::PH_SUPPORTED;
                end
                default: begin
                    // free (the unused code behaves as free)
                    if (in_limit) begin
                        step_phase = gdaq_pkg::PH_CANDIDATE;
                        step_start = stime;
                    end else begin
                        step_phase = gdaq_pkg::PH_FREE;
                    end
                end
            endcase
        end
    end

    assign acquired = (phase_reg != gdaq_pkg::PH_SUPPORTED)
                      && (step_phase == gdaq_pkg::PH_SUPPORTED);
    assign released = (phase_reg == gdaq_pkg::PH_SUPPORTED)
                      && (step_phase != gdaq_pkg::PH_SUPPORTED);

    // ------------------------------------------------------------------
    // Next values
    // ------------------------------------------------------------------
    always_comb begin
        in_valid_next      = in_valid_reg;
        in_data_next       = in_data_reg;
        out_valid_next     = out_valid_reg;
        out_data_next      = out_data_reg;
        phase_next         = phase_reg;
        bound_id_next      = bound_id_reg;
        cand_start_next    = cand_start_reg;
        acquire_limit_next = acquire_limit_reg;
        hold_time_next     = hold_time_reg;

        if (s_tready) begin
            in_valid_next = s_tvalid;
            in_data_next  = s_tdata;
        end
        if (advance) begin
            out_valid_next = in_valid_reg;
            out_data_next  = {released, acquired, step_phase};
        end
        if (fire) begin
            phase_next      = step_phase;
            bound_id_next   = step_bound;
            cand_start_next = step_start;
        end
        if (cfg_we) begin
            case (cfg_index)
                gdaq_pkg::CFG_ACQUIRE_LIMIT:
                    acquire_limit_next = cfg_wdata[gdaq_pkg::DIST_W-1:0];
                gdaq_pkg::CFG_HOLD_TIME:
                    hold_time_next = cfg_wdata[gdaq_pkg::TIME_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            phase_reg         <= gdaq_pkg::PH_FREE;
            bound_id_reg      <= '0;
            cand_start_reg    <= '0;
            acquire_limit_reg <= '0;
            hold_time_reg     <= '0;
        end else begin
            in_valid_reg      <= in_valid_next;
            out_valid_reg     <= out_valid_next;
            phase_reg         <= phase_next;
            bound_id_reg      <= bound_id_next;
            cand_start_reg    <= cand_start_next;
            acquire_limit_reg <= acquire_limit_next;
            hold_time_reg     <= hold_time_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        in_data_reg  <= in_data_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(gdaq_pkg::M_TDATA_W-4){1'b0}}, out_data_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `GDAQ_ASSERT(a_bound_when_active,
        (phase_reg != gdaq_pkg::PH_FREE) |-> (bound_id_reg != '0),
        "non-free phase without a binding")
    `GDAQ_ASSERT(a_acquired_is_supported,
        (m_tvalid && out_data_reg[2]) |-> (out_data_reg[1:0] == gdaq_pkg::PH_SUPPORTED),
        "acquired flagged but result state is not supported")
    `GDAQ_ASSERT(a_state_tracks_result,
        fire |=> (phase_reg == out_data_reg[1:0]),
        "result state differs from stored phase")
    `GDAQ_ASSERT_ALWAYS(a_reset_free,
        !aresetn |=> (phase_reg == gdaq_pkg::PH_FREE && !m_tvalid),
        "machine not free after reset")

endmodule

`default_nettype wire

// ----- tb/gdaq_support_checker.sv -----
// ----------------------------------------------------------------------------
// Grip dwell acquire qualifier: result checker
// Watches the sample, result and register write ports, runs its own
// acquisition machine on every accepted sample and compares each delivered
// result, field by field, against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module gdaq_support_checker
    import gdaq_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    input  wire logic                   s_tready,
    input  wire logic [S_TDATA_W-1:0]   s_tdata,
    input  wire logic                   m_tvalid,
    input  wire logic                   m_tready,
    input  wire logic [M_TDATA_W-1:0]   m_tdata,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
    output int                          errors,
    output int                          pending
);

    // sample layout, highest field first (matches s_tdata packing)
    typedef struct packed {
        logic              clear_request;
        logic [DIST_W-1:0] override_limit;
        logic              use_override;
        logic              native_target_active;
        logic              pose_valid;
        logic              grip_held;
        logic              grip_tracked;
        logic              session_focused;
        logic              numbers_valid;
        logic [DIST_W-1:0] support_distance;
        logic [TIME_W-1:0] sample_time;
        logic [ID_W-1:0]   binding_id;
    } sample_t;

    typedef struct packed {
        logic [3:0] pad;
        logic       released;
        logic       acquired;
        logic [1:0] state;
    } verdict_t;

    // shadow registers and machine state
    logic [DIST_W-1:0] acq_limit;
    logic [TIME_W-1:0] hold_us;
    phase_t            track_phase;
    logic [ID_W-1:0]   bound_id;
    logic [TIME_W-1:0] dwell_start;

    verdict_t pending_verdicts[$];
    int       result_no;

    task automatic report(input string what, input logic [31:0] got,
                          input logic [31:0] want);
        $display("mismatch on result %0d, %s: got %0d, expected %0d",
                 result_no, what, got, want);
        errors++;
    endtask

    // advances the shadow machine by one sample
    function automatic verdict_t qualify_sample(input sample_t smp);
        verdict_t          v;
        phase_t            was;
        logic [DIST_W-1:0] lim;
        logic              ok;

        was = track_phase;
        lim = smp.use_override ? smp.override_limit : acq_limit;
        ok  = (smp.binding_id != '0) && smp.numbers_valid && smp.session_focused
              && smp.grip_tracked && smp.grip_held && smp.pose_valid
              && !smp.native_target_active;

        if (smp.clear_request || !ok) begin
            track_phase = PH_FREE;
            bound_id    = '0;
            dwell_start = '0;
        end else begin
            if (bound_id != smp.binding_id) begin
                track_phase = PH_FREE;
                dwell_start = '0;
                bound_id    = smp.binding_id;
            end
            case (track_phase)
                PH_FREE: begin
                    if (smp.support_distance <= lim) begin
                        track_phase = PH_CANDIDATE;
                        dwell_start = smp.sample_time;
                    end
                end
                PH_CANDIDATE: begin
                    if (smp.support_distance > lim) begin
                        track_phase = PH_FREE;
                        dwell_start = '0;
                    end else if (smp.sample_time < dwell_start) begin
                        dwell_start = smp.sample_time;  // clock went backwards
                    end else if (smp.sample_time - dwell_start >= hold_us) begin
                        track_phase = PH_SUPPORTED;
                    end
                end
                default: ;
            endcase
        end

        v          = '0;
        v.state    = track_phase;
        v.acquired = (was != PH_SUPPORTED) && (track_phase == PH_SUPPORTED);
        v.released = (was == PH_SUPPORTED) && (track_phase != PH_SUPPORTED);
        return v;
    endfunction

    always @(posedge aclk) begin
        verdict_t got;
        verdict_t want;

        if (!aresetn) begin
            acq_limit   = '0;
            hold_us     = '0;
            track_phase = PH_FREE;
            bound_id    = '0;
            dwell_start = '0;
            result_no   = 0;
            errors      = 0;
            pending_verdicts.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_ACQUIRE_LIMIT: acq_limit = cfg_wdata[DIST_W-1:0];
                    CFG_HOLD_TIME:     hold_us   = cfg_wdata[TIME_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                pending_verdicts.push_back(qualify_sample(sample_t'(s_tdata)));
            if (m_tvalid && m_tready) begin
                got = verdict_t'(m_tdata);
                if (pending_verdicts.size() == 0) begin
                    report("no prediction waiting", 32'(got), 0);
                end else begin
                    want = pending_verdicts.pop_front();
                    if (got.state !== want.state)
                        report("support_state", 32'(got.state), 32'(want.state));
                    if (got.acquired !== want.acquired)
                        report("acquired", 32'(got.acquired), 32'(want.acquired));
                    if (got.released !== want.released)
                        report("released", 32'(got.released), 32'(want.released));
                    if (got.pad !== want.pad)
                        report("zero fill", 32'(got.pad), 32'(want.pad));
                end
                result_no++;
            end
        end
        pending = pending_verdicts.size();
    end

endmodule

`default_nettype wire

// ----- tb/tb_grip_dwell_acquire_qualifier_top.sv -----
// ----------------------------------------------------------------------------
// Grip dwell acquire qualifier testbench
// Drives directed and random tracking samples with random stalls on both
// streams, steps the limit and dwell registers through several settings,
// and leaves all result checking to the attached checker.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_grip_dwell_acquire_qualifier_top;
    import gdaq_pkg::*;

    localparam int IDLE_LIMIT    = 2000;  // cycles without any transaction
    localparam int RAND_PER_STEP = 300;   // random samples per register setting
    localparam int SETTINGS_N    = 6;

    // same layout as s_tdata, highest field first
    typedef struct packed {
        logic              clear_request;
        logic [DIST_W-1:0] override_limit;
        logic              use_override;
        logic              native_target_active;
        logic              pose_valid;
        logic              grip_held;
        logic              grip_tracked;
        logic              session_focused;
        logic              numbers_valid;
        logic [DIST_W-1:0] support_distance;
        logic [TIME_W-1:0] sample_time;
        logic [ID_W-1:0]   binding_id;
    } sample_t;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    int errors;
    int pending;

    // stimulus context: the object the hand is working on and its clock
    bit                quiet = 1'b0;   // no stalls on either side when set
    logic [ID_W-1:0]   cur_id;
    logic [TIME_W-1:0] cur_time;
    logic [DIST_W-1:0] reg_limit;
    int unsigned       time_step;
    int                stall_cycles;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    grip_dwell_acquire_qualifier_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    gdaq_support_checker u_checker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .errors    (errors),
        .pending   (pending)
    );

    // Result side back-pressure: random low bursts on m_tready, which gets at most
    // one update per falling edge.
    always begin
        @(negedge aclk);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            m_tready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
        m_tready <= 1'b1;
    end

    // Watchdog: any cycle with a transaction on either stream rearms it.
    initial begin
        stall_cycles = 0;
        while (stall_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // Fully valid sample; callers knock out fields for the special cases.
    function automatic sample_t tracked_sample(input logic [ID_W-1:0] id,
                                               input logic [TIME_W-1:0] t,
                                               input logic [DIST_W-1:0] distance);
        sample_t smp;
        smp                  = '0;
        smp.binding_id       = id;
        smp.sample_time      = t;
        smp.support_distance = distance;
        smp.numbers_valid    = 1'b1;
        smp.session_focused  = 1'b1;
        smp.grip_tracked     = 1'b1;
        smp.grip_held        = 1'b1;
        smp.pose_valid       = 1'b1;
        return smp;
    endfunction

    // Mostly a plausible hand: same object, time moving forward, distance
    // hovering around the limit. Some noise: lost tracking, clears, new ids.
    function automatic sample_t next_sample();
        sample_t smp;
        int      lim_i;
        int      pick;

        if ($urandom_range(0, 99) < 6)
            cur_id = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(1, 4);
        if ($urandom_range(0, 19) == 0)
            cur_time = cur_time - $urandom_range(1, time_step);
        else
            cur_time = cur_time + $urandom_range(0, time_step);

        smp                = tracked_sample(cur_id, cur_time, '0);
        smp.use_override   = ($urandom_range(0, 4) == 0);
        smp.override_limit = DIST_W'($urandom());
        lim_i = smp.use_override ? int'(smp.override_limit) : int'(reg_limit);
        if ($urandom_range(0, 3) != 0 || lim_i == 65535)
            smp.support_distance = DIST_W'($urandom_range(0, lim_i));
        else
            smp.support_distance = DIST_W'($urandom_range(lim_i + 1, 65535));

        pick = $urandom_range(0, 99);
        if (pick < 3) begin
            smp.clear_request = 1'b1;
        end else if (pick < 12) begin
            case ($urandom_range(0, 6))
                0: smp.numbers_valid        = 1'b0;
                1: smp.session_focused      = 1'b0;
                2: smp.grip_tracked         = 1'b0;
                3: smp.grip_held            = 1'b0;
                4: smp.pose_valid           = 1'b0;
                5: smp.native_target_active = 1'b1;
                default: smp.binding_id     = '0;
            endcase
        end
        return smp;
    endfunction

    // One sample transaction. Entered and left on a falling edge; tvalid
    // stays high into the next call unless a gap is inserted.
    task automatic send(input sample_t smp);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Stop sending and wait for every outstanding result, then let the
    // pipeline (two stages) settle.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        @(negedge aclk);
    endtask

    // Registers only change with the block idle.
    task automatic set_registers(input logic [DIST_W-1:0] lim,
                                 input logic [TIME_W-1:0] hold);
        drain();
        write_reg(CFG_ACQUIRE_LIMIT, CFG_DATA_W'(lim));
        write_reg(CFG_HOLD_TIME, hold);
        reg_limit = lim;
        time_step = (hold > 4000) ? 4000 : hold / 3 + 50;
        cur_time  = $urandom();
        cur_id    = $urandom_range(1, 4);
    endtask

    initial begin
        sample_t smp;
        int      k;
        int      step;
        int      n;

        reg_limit = '0;
        time_step = 50;
        cur_id    = 1;
        cur_time  = '0;

        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // ---- directed: limit 100 mm, dwell 1000 us ----
        set_registers(16'd100, 32'd1000);
        send(tracked_sample(7, 1000, 50));              // free -> candidate
        send(tracked_sample(7, 1500, 100));             // at the limit exactly
        send(tracked_sample(7, 2000, 100));             // dwell met -> supported
        send(tracked_sample(7, 2100, 16'hFFFF));        // far away, still held
        smp = tracked_sample(7, 2200, 0);
        smp.numbers_valid = 1'b0;                       // bad numbers release
        send(smp);
        send(tracked_sample(7, 3000, 0));
        send(tracked_sample(7, 2500, 0));               // time went backwards
        send(tracked_sample(7, 3400, 0));               // 900 us since restart
        send(tracked_sample(7, 3500, 0));               // supported
        send(tracked_sample(9, 3600, 0));               // new object: release
        send(tracked_sample(9, 3700, 101));             // just over: back to free
        smp = tracked_sample(9, 4000, 150);
        smp.use_override   = 1'b1;                      // per-sample limit wins
        smp.override_limit = 16'd200;
        send(smp);
        // every single validity loss except bad numbers, each from candidate
        for (k = 0; k < 6; k++) begin
            send(tracked_sample(9, 4100 + k, 0));
            smp = tracked_sample(9, 4200 + k, 0);
            case (k)
                0: smp.session_focused      = 1'b0;
                1: smp.grip_tracked         = 1'b0;
                2: smp.grip_held            = 1'b0;
                3: smp.pose_valid           = 1'b0;
                4: smp.native_target_active = 1'b1;
                default: smp.binding_id     = '0;
            endcase
            send(smp);
        end
        send(tracked_sample(9, 5000, 0));
        send(tracked_sample(9, 6000, 0));
        smp = tracked_sample(9, 6100, 0);
        smp.clear_request = 1'b1;                       // clear while supported
        send(smp);
        send(tracked_sample('1, '1, 0));                // all-ones id and time
        smp = tracked_sample(3, 0, 16'hFFFF);
        smp.use_override   = 1'b1;
        smp.override_limit = 16'hFFFF;
        send(smp);
        smp = tracked_sample(3, 10, 1);
        smp.use_override   = 1'b1;
        smp.override_limit = 16'd0;
        send(smp);

        // ---- directed: zero dwell, then the longest dwell ----
        set_registers(16'd0, 32'd0);
        send(tracked_sample(5, 10, 0));
        send(tracked_sample(5, 10, 0));                 // supported on next sample
        set_registers(16'hFFFF, 32'hFFFF_FFFF);
        send(tracked_sample(6, 0, 16'hFFFF));
        send(tracked_sample(6, 32'hFFFF_FFFF, 16'hFFFF));

        // ---- random: one block per register setting, last one without stalls ----
        for (step = 0; step < SETTINGS_N; step++) begin
            case (step)
                0: set_registers(16'd300, 32'd500);
                1: set_registers(16'd0, 32'd0);
                2: set_registers(16'hFFFF, 32'hFFFF_FFFF);
                3: set_registers(DIST_W'($urandom()), $urandom_range(0, 3000));
                4: set_registers(16'd1000, 32'd1);
                default: set_registers(DIST_W'($urandom()), $urandom_range(0, 2000));
            endcase
            quiet = (step == SETTINGS_N - 1);
            for (n = 0; n < RAND_PER_STEP; n++) begin
                if ($urandom_range(0, 149) == 0)
                    drain();                            // hold off until all results back
                send(next_sample());
            end
        end

        drain();
        repeat (8) @(negedge aclk);
        if (errors == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
